@@ sv/battery_charge_state_machine_defines.svh @@
// assertion macros shared by the battery charge block
`ifndef BATTERY_CHARGE_STATE_MACHINE_DEFINES_SVH
`define BATTERY_CHARGE_STATE_MACHINE_DEFINES_SVH
`ifndef SYNTHESIS
`define BCSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcsm assertion failed");
`define BCSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcsm assertion failed");
`else
`define BCSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BCSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/bcsm_pkg.sv @@
package bcsm_pkg;

	// mode codes as seen on the result
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_PRE  = 2'd1;
	localparam logic [1:0] MODE_CHG  = 2'd2;
	localparam logic [1:0] MODE_DIS  = 2'd3;

	// delay classes
	localparam logic [1:0] DLY_NONE = 2'd0;
	localparam logic [1:0] DLY_IDLE = 2'd1;
	localparam logic [1:0] DLY_CHG  = 2'd2;
	localparam logic [1:0] DLY_DIS  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_CHG_TMIN   = 3'd0;
	localparam logic [2:0] CFG_START_TMAX = 3'd1;
	localparam logic [2:0] CFG_CHG_TMAX   = 3'd2;
	localparam logic [2:0] CFG_DIS_TMAX   = 3'd3;
	localparam logic [2:0] CFG_LOW_PCT    = 3'd4;
	localparam logic [2:0] CFG_NOTIFY_US  = 3'd5;
	localparam logic [2:0] CFG_CHG_MASK   = 3'd6;
	localparam logic [2:0] CFG_DIS_MASK   = 3'd7;

	localparam logic [7:0] FULL_PERCENT = 8'd100;

	// deci-kelvin to celsius: offset and reciprocal of ten
	localparam logic [15:0] DK_OFFSET   = 16'd2731;
	localparam logic [16:0] RECIP_TEN   = 17'd104858;
	localparam int          RECIP_SHIFT = 20;

	typedef logic signed [13:0] temp_c_t;
	typedef logic signed [8:0]  cfg_temp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PRE  = 4'b0010,
		ST_CHG  = 4'b0100,
		ST_DIS  = 4'b1000
	} state_t;

	typedef struct packed {
		cfg_temp_t   chg_tmin;
		cfg_temp_t   start_tmax;
		cfg_temp_t   chg_tmax;
		cfg_temp_t   dis_tmax;
		logic [6:0]  low_pct;
		logic [31:0] notify_us;
		logic [15:0] chg_mask;
		logic [15:0] dis_mask;
	} cfg_t;

	typedef struct packed {
		logic        ac_present;
		logic        host_on;
		logic        temp_valid;
		temp_c_t     temp_c;
		logic        status_valid;
		logic [15:0] alarm_bits;
		logic        charge_valid;
		logic [7:0]  charge_percent;
		logic        charger_fault;
		logic [63:0] now_us;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       charger_on;
		logic       power_off;
		logic       low_notice;
		logic [1:0] delay_class;
	} result_t;

endpackage

@@ sv/bcsm_cfg_regs.sv @@
module bcsm_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_idx,
	input  logic [31:0]      cfg_wr_data,
	output bcsm_pkg::cfg_t   cfg
);

	bcsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chg_tmin   <= 9'sd5;
			cfg_q.start_tmax <= 9'sd40;
			cfg_q.chg_tmax   <= 9'sd60;
			cfg_q.dis_tmax   <= 9'sd70;
			cfg_q.low_pct    <= 7'd10;
			cfg_q.notify_us  <= 32'd60000000;
			cfg_q.chg_mask   <= 16'hD000;
			cfg_q.dis_mask   <= 16'h1800;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				bcsm_pkg::CFG_CHG_TMIN:   cfg_q.chg_tmin   <= cfg_wr_data[8:0];
				bcsm_pkg::CFG_START_TMAX: cfg_q.start_tmax <= cfg_wr_data[8:0];
				bcsm_pkg::CFG_CHG_TMAX:   cfg_q.chg_tmax   <= cfg_wr_data[8:0];
				bcsm_pkg::CFG_DIS_TMAX:   cfg_q.dis_tmax   <= cfg_wr_data[8:0];
				bcsm_pkg::CFG_LOW_PCT:    cfg_q.low_pct    <= cfg_wr_data[6:0];
				bcsm_pkg::CFG_NOTIFY_US:  cfg_q.notify_us  <= cfg_wr_data;
				bcsm_pkg::CFG_CHG_MASK:   cfg_q.chg_mask   <= cfg_wr_data[15:0];
				bcsm_pkg::CFG_DIS_MASK:   cfg_q.dis_mask   <= cfg_wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/bcsm_temp_conv.sv @@
module bcsm_temp_conv (
	input  logic [15:0]         temp_dk,
	output bcsm_pkg::temp_c_t   temp_c
);

	logic        neg;
	logic [15:0] mag;
	logic [32:0] prod;
	logic [12:0] quo;

	// truncation toward zero: divide the magnitude, then restore the sign
	always_comb begin
		neg    = temp_dk < bcsm_pkg::DK_OFFSET;
		mag    = neg ? (bcsm_pkg::DK_OFFSET - temp_dk) : (temp_dk - bcsm_pkg::DK_OFFSET);
		prod   = 33'(mag) * 33'(bcsm_pkg::RECIP_TEN);
		quo    = prod[bcsm_pkg::RECIP_SHIFT +: 13];
		temp_c = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	end

endmodule

@@ sv/bcsm_core.sv @@
module bcsm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  bcsm_pkg::item_t     item,
	input  bcsm_pkg::cfg_t      cfg,
	output bcsm_pkg::result_t   res
);

	bcsm_pkg::state_t  state_q, state_n;
	logic              chg_q, chg_n;
	logic [63:0]       last_q, last_n;
	bcsm_pkg::result_t res_q, res_n;

	bcsm_pkg::temp_c_t tmin, tstart, tchg, tdis;
	logic              in_start, in_chg, hot_dis, alarm_c, alarm_d, low_chg, notice_due;
	logic [63:0]       elapsed;
	logic [1:0]        dly;
	logic              poff, note;

	always_comb begin
		tmin       = bcsm_pkg::temp_c_t'(cfg.chg_tmin);
		tstart     = bcsm_pkg::temp_c_t'(cfg.start_tmax);
		tchg       = bcsm_pkg::temp_c_t'(cfg.chg_tmax);
		tdis       = bcsm_pkg::temp_c_t'(cfg.dis_tmax);
		in_start   = (item.temp_c > tmin) && (item.temp_c < tstart);
		in_chg     = (item.temp_c > tmin) && (item.temp_c < tchg);
		hot_dis    = item.temp_valid && !(item.temp_c < tdis);
		alarm_c    = (item.alarm_bits & cfg.chg_mask) != 16'd0;
		alarm_d    = item.status_valid && ((item.alarm_bits & cfg.dis_mask) != 16'd0);
		low_chg    = item.charge_valid && (item.charge_percent < {1'b0, cfg.low_pct});
		elapsed    = item.now_us - last_q;
		notice_due = item.host_on && (elapsed > {32'd0, cfg.notify_us});

		state_n = bcsm_pkg::ST_IDLE;
		dly     = bcsm_pkg::DLY_IDLE;
		poff    = 1'b0;
		note    = 1'b0;
		chg_n   = chg_q;
		last_n  = last_q;

		case (state_q)
			bcsm_pkg::ST_IDLE: begin
				if (!item.ac_present) begin
					if (item.host_on) begin
						state_n = bcsm_pkg::ST_DIS;
						dly     = bcsm_pkg::DLY_NONE;
					end else begin
						chg_n = 1'b1;
					end
				end else if (!item.temp_valid) begin
					chg_n   = 1'b1;
					state_n = bcsm_pkg::ST_PRE;
				end else if (!in_start) begin
					chg_n = 1'b0;
				end else if (!item.status_valid || alarm_c) begin
					chg_n = 1'b0;
				end else if (item.charge_valid && item.charge_percent < bcsm_pkg::FULL_PERCENT) begin
					chg_n   = 1'b1;
					state_n = bcsm_pkg::ST_CHG;
				end
			end
			bcsm_pkg::ST_PRE: begin
				if (item.ac_present) begin
					if (item.temp_valid) begin
						state_n = bcsm_pkg::ST_CHG;
						dly     = bcsm_pkg::DLY_NONE;
					end else begin
						state_n = bcsm_pkg::ST_PRE;
					end
				end
			end
			bcsm_pkg::ST_CHG: begin
				if (item.ac_present) begin
					if (!item.temp_valid || !in_chg) begin
						chg_n = 1'b0;
					end else if (!item.status_valid || alarm_c) begin
						chg_n = 1'b0;
					end else if (item.charger_fault) begin
						chg_n = 1'b0;
					end else begin
						state_n = bcsm_pkg::ST_CHG;
						dly     = bcsm_pkg::DLY_CHG;
					end
				end
			end
			bcsm_pkg::ST_DIS: begin
				if (!item.ac_present) begin
					if (hot_dis || alarm_d) begin
						chg_n = 1'b0;
						poff  = item.host_on;
					end else if (low_chg) begin
						if (notice_due) begin
							note   = 1'b1;
							last_n = item.now_us;
						end
						state_n = bcsm_pkg::ST_DIS;
						dly     = bcsm_pkg::DLY_NONE;
					end else begin
						state_n = bcsm_pkg::ST_DIS;
						dly     = bcsm_pkg::DLY_DIS;
					end
				end
			end
			default: ;
		endcase

		case (state_n)
			bcsm_pkg::ST_PRE: res_n.mode = bcsm_pkg::MODE_PRE;
			bcsm_pkg::ST_CHG: res_n.mode = bcsm_pkg::MODE_CHG;
			bcsm_pkg::ST_DIS: res_n.mode = bcsm_pkg::MODE_DIS;
			default:          res_n.mode = bcsm_pkg::MODE_IDLE;
		endcase
		res_n.charger_on  = chg_n;
		res_n.power_off   = poff;
		res_n.low_notice  = note;
		res_n.delay_class = dly;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcsm_pkg::ST_IDLE;
			chg_q   <= 1'b0;
			last_q  <= 64'd0;
		end else if (adv) begin
			state_q <= state_n;
			chg_q   <= chg_n;
			last_q  <= last_n;
		end
	end

	// result payload, qualified by the valid flag in the top level
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign res = res_q;

endmodule

@@ sv/battery_charge_state_machine.sv @@
// Battery charge mode controller. Each input transfer is one evaluation tick carrying AC and
// host power, battery temperature in deci-kelvin, alarm word, state of charge, charger fault
// and the microsecond time; each tick yields exactly one result transfer with the new mode,
// the charger enable level, a power-off request, a rate-limited low battery notice and the
// wait class that should follow. Throughput is one tick per clock while the result channel is
// not stalled; a tick passes through the input register (temperature converted to Celsius on
// the way in) and then the result register after the decision logic. Limits, alarm
// masks and the notice interval sit in a write-only register file; write it only while no
// tick is in flight.
`include "battery_charge_state_machine_defines.svh"

module battery_charge_state_machine (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wr_data,

	// tick input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        ac_present,
	input  logic        host_on,
	input  logic        temp_valid,
	input  logic [15:0] temp_dk,
	input  logic        status_valid,
	input  logic [15:0] alarm_bits,
	input  logic        charge_valid,
	input  logic [7:0]  charge_percent,
	input  logic        charger_fault,
	input  logic [63:0] now_us,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  mode,
	output logic        charger_on,
	output logic        power_off,
	output logic        low_notice,
	output logic [1:0]  delay_class
);

	bcsm_pkg::cfg_t    cfg;
	bcsm_pkg::temp_c_t temp_c;
	bcsm_pkg::item_t   item_in;
	bcsm_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              adv;
	logic              in_xfer;
	bcsm_pkg::result_t res;

	bcsm_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_idx     (cfg_idx),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	// celsius conversion ahead of the input register keeps the multiply off the decision path
	bcsm_temp_conv u_temp (
		.temp_dk (temp_dk),
		.temp_c  (temp_c)
	);

	always_comb begin
		item_in.ac_present     = ac_present;
		item_in.host_on        = host_on;
		item_in.temp_valid     = temp_valid;
		item_in.temp_c         = temp_c;
		item_in.status_valid   = status_valid;
		item_in.alarm_bits     = alarm_bits;
		item_in.charge_valid   = charge_valid;
		item_in.charge_percent = charge_percent;
		item_in.charger_fault  = charger_fault;
		item_in.now_us         = now_us;
	end

	// the held tick moves into the result register whenever that register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	// input stage frees itself in the same cycle it advances, so back-to-back transfers flow
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item_in;
		end
	end

	// decision logic, mode state, charger level and last notice time
	bcsm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign mode        = res.mode;
	assign charger_on  = res.charger_on;
	assign power_off   = res.power_off;
	assign low_notice  = res.low_notice;
	assign delay_class = res.delay_class;

	// a power-off request only comes out of the forced-off path, which lands in idle with charger off
	`BCSM_ASSERT_IMP(a_poff_idle, clk, arst_n, out_valid && power_off, (mode == bcsm_pkg::MODE_IDLE) && !charger_on)
	// a low notice only comes from the low-charge discharge path
	`BCSM_ASSERT_IMP(a_notice_dis, clk, arst_n, out_valid && low_notice, (mode == bcsm_pkg::MODE_DIS) && (delay_class == bcsm_pkg::DLY_NONE))
	// the charging wait class only follows a tick that stays in charging
	`BCSM_ASSERT_IMP(a_chg_dly, clk, arst_n, out_valid && (delay_class == bcsm_pkg::DLY_CHG), mode == bcsm_pkg::MODE_CHG)
	// an advancing tick always shows up as a result in the next cycle
	`BCSM_ASSERT_NXT(a_adv_out, clk, arst_n, adv, out_valid)

endmodule
